// ===== hw/rtl/fwr_pkg.sv =====
// Package for the full-weighting restriction block.
// Holds widths, depths and the result type shared by the line store, the output queue and the top level.
// Depends on nothing.
package fwr_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int MAX_INTERVALS = 1024;
    localparam int STORE_DEPTH   = MAX_INTERVALS + 1;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CFG_W         = 11;
    localparam int IDX_W         = 10;
    localparam int COL_W         = SAMPLE_W + 2;
    localparam int SUM_W         = SAMPLE_W + 4;
    localparam int LS_W          = 2 * SAMPLE_W;
    localparam int MIN_POINTS    = 3;
    localparam int MAX_POINTS    = MAX_INTERVALS + 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           coarse_row;
        logic [IDX_W-1:0]           coarse_col;
        logic                       last;
    } fwr_result_t;

endpackage

// ===== hw/rtl/fwr_line_store.sv =====
// Line store: two fine rows packed side by side in one synchronous memory.
// Read data is registered and appears in the cycle after the read. Depends on fwr_pkg.
module fwr_line_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [fwr_pkg::ADDR_W-1:0] wr_addr,
    input  logic [fwr_pkg::LS_W-1:0]   wr_data,
    input  logic                       rd_en,
    input  logic [fwr_pkg::ADDR_W-1:0] rd_addr,
    output logic [fwr_pkg::LS_W-1:0]   rd_data
);
    import fwr_pkg::*;

    logic [LS_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/fwr_out_fifo.sv =====
// Small result queue that decouples the arithmetic pipeline from the output handshake.
// Depends on fwr_pkg for the result type and the queue depth.
module fwr_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  fwr_pkg::fwr_result_t          push_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fwr_pkg::fwr_result_t          out_data,
    output logic [fwr_pkg::FIFO_CNT_W-1:0] count
);
    import fwr_pkg::*;

    fwr_result_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/full_weighting_restriction.sv =====
// Top level of the 2-D full-weighting restriction over a raster stream of fine samples.
// Depends on fwr_pkg, fwr_line_store and fwr_out_fifo.
//
//   Channel   Direction   Ports                                         Handshake
//   input     in          s_valid s_ready s_sample                      valid/ready
//   result    out         m_valid m_ready m_value m_coarse_row          valid/ready
//                         m_coarse_col m_last
//   config    in          cfg_wr_en cfg_wr_data                         write strobe
//
// One fine sample is taken per cycle while s_ready is high; once the transaction that completes
// a window is accepted, its coarse point passes the line store read, the sum and the result queue.
// The line store has one read and one write port, so each sample costs one read and one
// write in consecutive cycles. After reset the line store needs no clearing pass.
// Input ready drops only when the four-entry result queue and the results in flight would
// overfill it, so output stalls back up to the input after about four results.
module full_weighting_restriction (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [fwr_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [fwr_pkg::SAMPLE_W-1:0]  m_value,
    output logic [fwr_pkg::IDX_W-1:0]            m_coarse_row,
    output logic [fwr_pkg::IDX_W-1:0]            m_coarse_col,
    output logic                                 m_last,
    input  logic                                 cfg_wr_en,
    input  logic [fwr_pkg::CFG_W-1:0]            cfg_wr_data
);
    import fwr_pkg::*;

    // Geometry derived from the configured size.
    logic [CFG_W-1:0]  last_idx_reg;
    logic [CFG_W-1:0]  top_reg;
    logic [IDX_W-1:0]  nc_reg;
    logic [CFG_W-1:0]  eff_points;
    logic [CFG_W-1:0]  eff_last;

    // Raster position.
    logic [CFG_W-1:0]  row_reg;
    logic [CFG_W-1:0]  col_reg;

    // Accept-stage decode.
    logic              accept;
    logic              emit;
    logic              row_hit;
    logic              col_hit;
    logic [IDX_W-1:0]  ci;
    logic [IDX_W-1:0]  cj;
    logic              interior;
    logic              in_store;

    // Stage 1: line store data arrives.
    logic                       s1_valid_reg;
    logic                       s1_emit_reg;
    logic                       s1_interior_reg;
    logic                       s1_last_reg;
    logic                       s1_in_store_reg;
    logic [IDX_W-1:0]           s1_ci_reg;
    logic [IDX_W-1:0]           s1_cj_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_cur_reg;
    logic [LS_W-1:0]            rd_data;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [COL_W-1:0]    col_now;
    logic signed [SUM_W-1:0]    sum_next;

    // Column sums of the two previous columns.
    logic signed [COL_W-1:0]    col1_reg;
    logic signed [COL_W-1:0]    col2_reg;

    // Stage 2: full weighted sum.
    logic                       s2_valid_reg;
    logic                       s2_interior_reg;
    logic                       s2_last_reg;
    logic [IDX_W-1:0]           s2_ci_reg;
    logic [IDX_W-1:0]           s2_cj_reg;
    logic signed [SUM_W-1:0]    s2_sum_reg;

    fwr_result_t                push_data;
    fwr_result_t                out_data;
    logic [FIFO_CNT_W-1:0]      fifo_count;
    logic [FIFO_CNT_W:0]        pending;

    always_comb begin
        if (cfg_wr_data < CFG_W'(MIN_POINTS)) begin
            eff_points = CFG_W'(MIN_POINTS);
        end else if (cfg_wr_data > CFG_W'(MAX_POINTS)) begin
            eff_points = CFG_W'(MAX_POINTS);
        end else begin
            eff_points = cfg_wr_data;
        end
        eff_last = eff_points - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= CFG_W'(MAX_POINTS - 1);
            top_reg      <= CFG_W'(2 * ((MAX_POINTS - 1) / 2));
            nc_reg       <= IDX_W'((MAX_POINTS - 1) / 2);
        end else if (cfg_wr_en) begin
            last_idx_reg <= eff_last;
            top_reg      <= {eff_last[CFG_W-1:1], 1'b0};
            nc_reg       <= eff_last[CFG_W-1:1];
        end
    end

    assign pending = (FIFO_CNT_W+1)'(fifo_count)
                   + (FIFO_CNT_W+1)'(s1_valid_reg && s1_emit_reg)
                   + (FIFO_CNT_W+1)'(s2_valid_reg);
    assign s_ready = (pending < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_hit  = (row_reg <= top_reg) && (row_reg[0] || (row_reg == top_reg));
        col_hit  = (col_reg <= top_reg) && (col_reg[0] || (col_reg == top_reg));
        emit     = row_hit && col_hit;
        ci       = row_reg[0] ? row_reg[CFG_W-1:1] : nc_reg;
        cj       = col_reg[0] ? col_reg[CFG_W-1:1] : nc_reg;
        interior = (ci != '0) && (ci < nc_reg) && (cj != '0) && (cj < nc_reg);
        in_store = (col_reg < CFG_W'(STORE_DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (col_reg >= last_idx_reg) begin
                col_reg <= '0;
                row_reg <= (row_reg >= last_idx_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    fwr_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg && s1_in_store_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({lo, s1_cur_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg     <= emit;
            s1_interior_reg <= interior;
            s1_last_reg     <= (ci == nc_reg) && (cj == nc_reg);
            s1_in_store_reg <= in_store;
            s1_ci_reg       <= ci;
            s1_cj_reg       <= cj;
            s1_addr_reg     <= col_reg[ADDR_W-1:0];
            s1_cur_reg      <= s_sample;
        end
    end

    always_comb begin
        up       = s1_in_store_reg ? $signed(rd_data[LS_W-1:SAMPLE_W]) : '0;
        lo       = s1_in_store_reg ? $signed(rd_data[SAMPLE_W-1:0]) : '0;
        col_now  = COL_W'(up) + (COL_W'(lo) <<< 1) + COL_W'(s1_cur_reg);
        sum_next = SUM_W'(col2_reg) + (SUM_W'(col1_reg) <<< 1) + SUM_W'(col_now);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            col1_reg     <= '0;
            col2_reg     <= '0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg) begin
                col2_reg <= col1_reg;
                col1_reg <= col_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_sum_reg      <= sum_next;
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
            s2_ci_reg       <= s1_ci_reg;
            s2_cj_reg       <= s1_cj_reg;
        end
    end

    always_comb begin
        push_data.value      = s2_interior_reg ? s2_sum_reg[SUM_W-1:4] : '0;
        push_data.coarse_row = s2_ci_reg;
        push_data.coarse_col = s2_cj_reg;
        push_data.last       = s2_last_reg;
    end

    fwr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_value      = out_data.value;
    assign m_coarse_row = out_data.coarse_row;
    assign m_coarse_col = out_data.coarse_col;
    assign m_last       = out_data.last;

endmodule
